// File: hdl/ceq_pkg.sv
// shared types, codes and field widths of the coalescing event queue
package ceq_pkg;

  // field widths of the channel payloads
  localparam int unsigned KIND_W = 3;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned RK_W   = 2;

  // input commands
  localparam logic CMD_POST  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_ITEM       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME_TREE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MAP_FRAME  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LAYER_TREE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ROOT       = 3'd4;

  // event operations
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  // result kinds
  localparam logic [RK_W-1:0] RES_POST  = 2'd0;
  localparam logic [RK_W-1:0] RES_EVENT = 2'd1;
  localparam logic [RK_W-1:0] RES_EMPTY = 2'd2;

  // effect of a posted event on one queued entry
  typedef enum logic [1:0] {
    EFF_KEEP,
    EFF_DROP,
    EFF_CANCEL
  } effect_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DRAIN,
    ST_EMPTY
  } state_e;

  // one result item
  typedef struct packed {
    logic [RK_W-1:0]   result_kind;
    logic [KIND_W-1:0] out_kind;
    logic [OP_W-1:0]   out_op;
    logic [ID_W-1:0]   out_first;
    logic [ID_W-1:0]   out_second;
    logic              appended;
    logic [CNT_W-1:0]  removed_count;
    logic              overflow;
    logic [CNT_W-1:0]  live_count;
    logic              last;
  } result_t;

endpackage

// File: hdl/ceq_if.sv
// valid/ready channel interfaces for commands and results

// command channel
interface ceq_evt_if import ceq_pkg::*;;
  logic              valid;
  logic              ready;
  logic              command;
  logic [KIND_W-1:0] event_kind;
  logic [OP_W-1:0]   event_op;
  logic [ID_W-1:0]   first_id;
  logic [ID_W-1:0]   second_id;

  modport source (
    output valid, command, event_kind, event_op, first_id, second_id,
    input  ready
  );
  modport sink (
    input  valid, command, event_kind, event_op, first_id, second_id,
    output ready
  );
endinterface

// result channel
interface ceq_res_if import ceq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RK_W-1:0]   result_kind;
  logic [KIND_W-1:0] out_kind;
  logic [OP_W-1:0]   out_op;
  logic [ID_W-1:0]   out_first;
  logic [ID_W-1:0]   out_second;
  logic              appended;
  logic [CNT_W-1:0]  removed_count;
  logic              overflow;
  logic [CNT_W-1:0]  live_count;
  logic              last;

  modport source (
    output valid, result_kind, out_kind, out_op, out_first, out_second,
           appended, removed_count, overflow, live_count, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_kind, out_op, out_first, out_second,
           appended, removed_count, overflow, live_count, last,
    output ready
  );
endinterface

// File: hdl/ceq_effect.sv
// compare unit: effect of the posted event on one queued entry
module ceq_effect import ceq_pkg::*; #(
  parameter int unsigned SW = 16
) (
  input  logic [KIND_W-1:0] new_kind_i,
  input  logic [OP_W-1:0]   new_op_i,
  input  logic [SW-1:0]     new_first_i,
  input  logic [SW-1:0]     new_second_i,
  input  logic [KIND_W-1:0] q_kind_i,
  input  logic [OP_W-1:0]   q_op_i,
  input  logic [SW-1:0]     q_first_i,
  input  logic [SW-1:0]     q_second_i,
  output effect_e           effect_o
);

  logic same_kind;
  logic same_ids;
  logic names_item;
  logic q_live_op;

  // shared equality terms
  assign same_kind  = (new_kind_i == q_kind_i);
  assign same_ids   = (new_first_i == q_first_i) && (new_second_i == q_second_i);
  assign names_item = (new_first_i == q_first_i) || (new_first_i == q_second_i);
  assign q_live_op  = (q_op_i == OP_ADD) || (q_op_i == OP_UPDATE);

  // decode by operation, then by kind
  always_comb begin
    effect_o = EFF_KEEP;
    unique case (new_op_i)
      OP_UPDATE: begin
        if (same_kind && (q_op_i == OP_UPDATE) && same_ids) effect_o = EFF_DROP;
      end
      OP_REMOVE: begin
        unique case (new_kind_i) inside
          KIND_FRAME_TREE, KIND_MAP_FRAME, KIND_LAYER_TREE: begin
            if (same_kind && same_ids) effect_o = EFF_CANCEL;
          end
          KIND_ITEM: begin
            if (names_item && q_live_op) begin
              effect_o = (q_kind_i == KIND_ITEM) ? EFF_CANCEL : EFF_DROP;
            end
          end
          KIND_ROOT: begin
            if ((q_kind_i == KIND_ROOT) && (new_first_i == q_first_i)) effect_o = EFF_CANCEL;
          end
          default: effect_o = EFF_KEEP;
        endcase
      end
      default: effect_o = EFF_KEEP;
    endcase
  end

endmodule

// File: hdl/ceq_outbuf.sv
// output register between the sequencer and the result channel
module ceq_outbuf import ceq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  result_t       res_i,
  output logic          free_o,
  ceq_res_if.source     res_o
);

  logic    valid_q;
  result_t res_q;

  // slot is free when empty or being emptied this cycle
  assign free_o = !valid_q || res_o.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // held result
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) res_q <= res_i;
  end

  // drive the channel
  assign res_o.valid         = valid_q;
  assign res_o.result_kind   = res_q.result_kind;
  assign res_o.out_kind      = res_q.out_kind;
  assign res_o.out_op        = res_q.out_op;
  assign res_o.out_first     = res_q.out_first;
  assign res_o.out_second    = res_q.out_second;
  assign res_o.appended      = res_q.appended;
  assign res_o.removed_count = res_q.removed_count;
  assign res_o.overflow      = res_q.overflow;
  assign res_o.live_count    = res_q.live_count;
  assign res_o.last          = res_q.last;

endmodule

// File: hdl/coalescing_event_queue_unit.sv
// coalescing event queue: top level with sequencer and event memory
//
// Commands arrive on evt_i, one transfer per command; results leave on res_o.
// A post (command 0) walks the queued entries oldest first through one
// compare unit, one entry per cycle, compacting survivors in place, then
// appends the event unless it was cancelled or the queue is full, and
// returns one status result. A drain (command 1) reads the memory one entry
// per cycle while the output register is free and returns one result per
// queued event, the last one marked, or a single empty result for an empty
// queue. The event memory has a single read port and there is one compare
// unit; one command is worked on at a time and evt_i.ready is high only
// between commands.
// The last result sits in an output register, so the next command is taken
// while it waits. When the receiver stalls, the sequencer holds at the point
// where it must load a result and resumes when the register frees.
// Reset empties the queue and the output register; the memory contents are
// not cleared, since only entries below the live count are ever used.
module coalescing_event_queue_unit import ceq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ceq_evt_if.sink    evt_i,
  ceq_res_if.source  res_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned EW = KIND_W + OP_W + 2 * SW;

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] w_q, w_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          cancel_q, cancel_d;

  logic [KIND_W-1:0] ev_kind_q;
  logic [OP_W-1:0]   ev_op_q;
  logic [SW-1:0]     ev_first_q;
  logic [SW-1:0]     ev_second_q;

  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic [KIND_W-1:0] q_kind;
  logic [OP_W-1:0]   q_op;
  logic [SW-1:0]     q_first;
  logic [SW-1:0]     q_second;

  effect_e effect;
  logic    evt_acc;
  logic    last_idx;
  logic    room;
  logic    do_app;
  logic    out_free;
  logic    out_load;
  result_t out_res;

  // fields of the entry read last cycle
  assign q_kind   = rdata_q[EW-1 -: KIND_W];
  assign q_op     = rdata_q[EW-KIND_W-1 -: OP_W];
  assign q_first  = rdata_q[2*SW-1 -: SW];
  assign q_second = rdata_q[SW-1:0];

  // handshake and scan status
  assign evt_i.ready = (state_q == ST_IDLE);
  assign evt_acc     = evt_i.valid && evt_i.ready;
  assign last_idx    = ((CW'(idx_q) + CW'(1)) == cnt_q);
  assign room        = (w_q < CW'(QUEUE_DEPTH));
  assign do_app      = !cancel_q && room;

  // shared compare unit
  ceq_effect #(
    .SW (SW)
  ) u_effect (
    .new_kind_i   (ev_kind_q),
    .new_op_i     (ev_op_q),
    .new_first_i  (ev_first_q),
    .new_second_i (ev_second_q),
    .q_kind_i     (q_kind),
    .q_op_i       (q_op),
    .q_first_i    (q_first),
    .q_second_i   (q_second),
    .effect_o     (effect)
  );

  // output register
  ceq_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (out_res),
    .free_o (out_free),
    .res_o  (res_o)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (evt_acc) begin
          if (evt_i.command == CMD_DRAIN) begin
            state_d = (cnt_q == '0) ? ST_EMPTY : ST_DRAIN;
          end else begin
            state_d = (cnt_q == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN:   if (last_idx) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      ST_DRAIN:  if (out_free && last_idx) state_d = ST_IDLE;
      ST_EMPTY:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control and result assembly
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    w_d       = w_q;
    rem_d     = rem_q;
    cancel_d  = cancel_q;
    mem_we    = 1'b0;
    mem_waddr = w_q[IW-1:0];
    mem_wdata = rdata_q;
    out_load  = 1'b0;
    out_res   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (evt_acc) begin
          idx_d    = '0;
          w_d      = '0;
          rem_d    = '0;
          cancel_d = 1'b0;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + IW'(1);
        if (effect == EFF_KEEP) begin
          mem_we = 1'b1;
          w_d    = w_q + CW'(1);
        end else begin
          rem_d = rem_q + CW'(1);
          if (effect == EFF_CANCEL) cancel_d = 1'b1;
        end
      end
      ST_FINISH: begin
        mem_wdata             = {ev_kind_q, ev_op_q, ev_first_q, ev_second_q};
        out_res.result_kind   = RES_POST;
        out_res.appended      = do_app;
        out_res.removed_count = CNT_W'(rem_q);
        out_res.overflow      = !cancel_q && !room;
        out_res.live_count    = CNT_W'(do_app ? (w_q + CW'(1)) : w_q);
        out_res.last          = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          mem_we   = do_app;
          cnt_d    = do_app ? (w_q + CW'(1)) : w_q;
        end
      end
      ST_DRAIN: begin
        out_res.result_kind = RES_EVENT;
        out_res.out_kind    = q_kind;
        out_res.out_op      = q_op;
        out_res.out_first   = ID_W'(q_first);
        out_res.out_second  = ID_W'(q_second);
        out_res.last        = last_idx;
        if (out_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + IW'(1);
          if (last_idx) cnt_d = '0;
        end
      end
      ST_EMPTY: begin
        out_res.result_kind = RES_EMPTY;
        out_res.last        = 1'b1;
        out_load            = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      w_q      <= '0;
      rem_q    <= '0;
      cancel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      w_q      <= w_d;
      rem_q    <= rem_d;
      cancel_q <= cancel_d;
    end
  end

  // posted event, ids cut to their stored width
  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      ev_kind_q   <= evt_i.event_kind;
      ev_op_q     <= evt_i.event_op;
      ev_first_q  <= evt_i.first_id[SW-1:0];
      ev_second_q <= evt_i.second_id[SW-1:0];
    end
  end

  // event memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[idx_d];
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("live count above queue depth");

  a_scan_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((w_q + rem_q) == CW'(idx_q)))
    else $error("kept plus removed entries differ from scan index");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && mem_we) |-> (w_q <= CW'(idx_q)))
    else $error("compaction write ahead of scan");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && out_free && last_idx) |=> (cnt_q == '0))
    else $error("queue not empty after drain");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_DRAIN) |-> (cnt_q != '0))
    else $error("scan or drain of an empty queue");
`endif

endmodule

// File: dv/coalescing_event_queue_unit_tb.sv
// self-checking testbench of the coalescing event queue unit
module coalescing_event_queue_unit_tb import ceq_pkg::*;;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 16;
  localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_BITS);

  // encodings the block stores but gives no meaning
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STUCK_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS   = 125;
  localparam int unsigned FILL_ITEMS    = 24;
  localparam int unsigned DIR_ROWS      = 24;
  localparam int unsigned SEND_IDLE [4] = '{0, 69, 0, 9};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 69, 9};

  typedef struct packed {
    logic              command;
    logic [KIND_W-1:0] kind;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   first_id;
    logic [ID_W-1:0]   second_id;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   first;
    logic [ID_W-1:0]   second;
  } event_t;

  typedef struct packed {
    cmd_t    c;
    logic    typed;
    result_t res;
  } row_t;

  localparam result_t NO_RES = '0;

  logic clk_i;
  logic rst_ni;

  ceq_evt_if evt ();
  ceq_res_if res ();

  coalescing_event_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .res_o (res)
  );

  // shadow of the queue contents and results still owed by the block
  event_t      shadow_q[$];
  event_t      recent_q[$];
  result_t     owed_q[$];
  int unsigned mismatches;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t post_st(logic app, int unsigned rem, logic ovf,
                                      int unsigned live);
    result_t r;
    r = '0;
    r.result_kind   = RES_POST;
    r.appended      = app;
    r.removed_count = CNT_W'(rem);
    r.overflow      = ovf;
    r.live_count    = CNT_W'(live);
    r.last          = 1'b1;
    return r;
  endfunction

  // what a newly posted event does to one queued entry
  function automatic effect_e merge_effect(event_t n, event_t q);
    if (n.op == OP_UPDATE) begin
      return (n == q) ? EFF_DROP : EFF_KEEP;
    end
    if (n.op == OP_REMOVE) begin
      case (n.kind)
        KIND_FRAME_TREE, KIND_MAP_FRAME, KIND_LAYER_TREE: begin
          return (n.kind == q.kind && n.first == q.first && n.second == q.second) ?
                 EFF_CANCEL : EFF_KEEP;
        end
        KIND_ITEM: begin
          if ((n.first == q.first || n.first == q.second) &&
              (q.op == OP_ADD || q.op == OP_UPDATE)) begin
            return (q.kind == KIND_ITEM) ? EFF_CANCEL : EFF_DROP;
          end
        end
        KIND_ROOT: begin
          return (q.kind == KIND_ROOT && n.first == q.first) ? EFF_CANCEL : EFF_KEEP;
        end
        default: ;
      endcase
    end
    return EFF_KEEP;
  endfunction

  // work out the results of one accepted command and update the shadow queue
  task automatic apply_cmd(input cmd_t c, input logic typed, input result_t typed_res);
    event_t      ev;
    event_t      kept[$];
    result_t     r;
    effect_e     eff;
    int unsigned removed;
    bit          cancelled;
    r = '0;
    if (c.command == CMD_DRAIN) begin
      if (shadow_q.size() == 0) begin
        r.result_kind = RES_EMPTY;
        r.last        = 1'b1;
        owed_q = {owed_q, r};
      end else begin
        foreach (shadow_q[i]) begin
          r.result_kind = RES_EVENT;
          r.out_kind    = shadow_q[i].kind;
          r.out_op      = shadow_q[i].op;
          r.out_first   = shadow_q[i].first;
          r.out_second  = shadow_q[i].second;
          r.last        = (i == shadow_q.size() - 1);
          owed_q = {owed_q, r};
        end
        shadow_q.delete();
      end
    end else begin
      ev = '{c.kind, c.op, c.first_id & ID_MASK, c.second_id & ID_MASK};
      removed   = 0;
      cancelled = 1'b0;
      foreach (shadow_q[i]) begin
        eff = merge_effect(ev, shadow_q[i]);
        if (eff == EFF_KEEP) begin
          kept = {kept, shadow_q[i]};
        end else begin
          removed++;
          if (eff == EFF_CANCEL) cancelled = 1'b1;
        end
      end
      shadow_q = kept;
      r = post_st(1'b0, removed, 1'b0, 0);
      if (!cancelled) begin
        if (shadow_q.size() < QUEUE_DEPTH) begin
          shadow_q = {shadow_q, ev};
          r.appended = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
      r.live_count = CNT_W'(shadow_q.size());
      owed_q = {owed_q, r};
      recent_q = {recent_q, ev};
      if (recent_q.size() > QUEUE_DEPTH) void'(recent_q.pop_front());
    end
    // rows with a hand-written result replace the computed one
    if (typed) owed_q[owed_q.size() - 1] = typed_res;
  endtask

  // ids mostly from a small pool so that entries collide
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return ID_W'($urandom_range(7));
    if (p < 70) return {ID_W{1'b1}};
    return ID_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t   c;
    event_t old;
    c.command = ($urandom_range(99) < 8) ? CMD_DRAIN : CMD_POST;
    c.kind    = ($urandom_range(99) < 5) ?
                KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO)) :
                KIND_W'($urandom_range(KIND_ROOT));
    c.op      = ($urandom_range(99) < 5) ? OP_UNUSED : OP_W'($urandom_range(OP_UPDATE));
    c.first_id  = pick_id();
    c.second_id = pick_id();
    // replay a recent event, mostly as a remove, to hit merges and cancels
    if (recent_q.size() != 0 && $urandom_range(99) < 45) begin
      old         = recent_q[$urandom_range(recent_q.size() - 1)];
      c.kind      = old.kind;
      c.first_id  = old.first;
      c.second_id = old.second;
      c.op        = ($urandom_range(99) < 60) ? OP_REMOVE : old.op;
    end
    return c;
  endfunction

  // offer one command from a falling edge and hold it until the transfer
  task automatic send_cmd(input cmd_t c, input logic typed, input result_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      evt.valid = 1'b0;
      @(negedge clk_i);
    end
    evt.valid      = 1'b1;
    evt.command    = c.command;
    evt.event_kind = c.kind;
    evt.event_op   = c.op;
    evt.first_id   = c.first_id;
    evt.second_id  = c.second_id;
    do @(posedge clk_i); while (!evt.ready);
    apply_cmd(c, typed, typed_res);
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    evt.valid = 1'b0;
    while (owed_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic note_bad(input string what, input longint unsigned want,
                          input longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // result receiver: random stalls plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        res.ready = 1'b0;
        hold_left--;
      end else begin
        res.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each result transfer with the oldest owed result
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res.valid && res.ready) begin
      got = '{res.result_kind, res.out_kind, res.out_op, res.out_first, res.out_second,
              res.appended, res.removed_count, res.overflow, res.live_count, res.last};
      if (owed_q.size() == 0) begin
        note_bad("result with nothing outstanding", 0, got);
      end else begin
        want = owed_q.pop_front();
        if (want.result_kind !== got.result_kind)
          note_bad("result_kind", want.result_kind, got.result_kind);
        if (want.out_kind !== got.out_kind) note_bad("out_kind", want.out_kind, got.out_kind);
        if (want.out_op !== got.out_op) note_bad("out_op", want.out_op, got.out_op);
        if (want.out_first !== got.out_first)
          note_bad("out_first", want.out_first, got.out_first);
        if (want.out_second !== got.out_second)
          note_bad("out_second", want.out_second, got.out_second);
        if (want.appended !== got.appended)
          note_bad("appended", want.appended, got.appended);
        if (want.removed_count !== got.removed_count)
          note_bad("removed_count", want.removed_count, got.removed_count);
        if (want.overflow !== got.overflow)
          note_bad("overflow", want.overflow, got.overflow);
        if (want.live_count !== got.live_count)
          note_bad("live_count", want.live_count, got.live_count);
        if (want.last !== got.last) note_bad("last", want.last, got.last);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    int unsigned stuck;
    if ((evt.valid && evt.ready) || (res.valid && res.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("coalescing_event_queue_unit regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    row_t dir_tab[DIR_ROWS];
    cmd_t c;

    mismatches     = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    rst_ni         = 1'b0;
    evt.valid      = 1'b0;
    evt.command    = CMD_POST;
    evt.event_kind = KIND_ITEM;
    evt.event_op   = OP_ADD;
    evt.first_id   = '0;
    evt.second_id  = '0;

    dir_tab = '{
      // empty drain right after reset
      '{'{CMD_DRAIN, KIND_ITEM, OP_ADD, 16'h0000, 16'h0000}, 1'b1,
        '{RES_EMPTY, 3'd0, 2'd0, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b1}},
      '{'{CMD_POST, KIND_ITEM, OP_ADD, 16'h0000, 16'h0000}, 1'b1, post_st(1, 0, 0, 1)},
      '{'{CMD_POST, KIND_ITEM, OP_ADD, 16'hFFFF, 16'hFFFF}, 1'b1, post_st(1, 0, 0, 2)},
      // repeated update replaces the queued one
      '{'{CMD_POST, KIND_ITEM, OP_UPDATE, 16'h0005, 16'h0006}, 1'b1, post_st(1, 0, 0, 3)},
      '{'{CMD_POST, KIND_ITEM, OP_UPDATE, 16'h0005, 16'h0006}, 1'b1, post_st(1, 1, 0, 3)},
      // link removes cancel against a matching link
      '{'{CMD_POST, KIND_FRAME_TREE, OP_ADD, 16'h0001, 16'h0002}, 1'b1, post_st(1, 0, 0, 4)},
      '{'{CMD_POST, KIND_FRAME_TREE, OP_REMOVE, 16'h0001, 16'h0002}, 1'b1,
        post_st(0, 1, 0, 3)},
      '{'{CMD_POST, KIND_MAP_FRAME, OP_ADD, 16'h0003, 16'h0004}, 1'b1, post_st(1, 0, 0, 4)},
      '{'{CMD_POST, KIND_LAYER_TREE, OP_UPDATE, 16'h0007, 16'h0008}, 1'b1,
        post_st(1, 0, 0, 5)},
      '{'{CMD_POST, KIND_MAP_FRAME, OP_REMOVE, 16'h0003, 16'h0004}, 1'b1,
        post_st(0, 1, 0, 4)},
      '{'{CMD_POST, KIND_LAYER_TREE, OP_REMOVE, 16'h0007, 16'h0008}, 1'b1,
        post_st(0, 1, 0, 3)},
      // root remove ignores the second id
      '{'{CMD_POST, KIND_ROOT, OP_ADD, 16'h0009, 16'h0000}, 1'b1, post_st(1, 0, 0, 4)},
      '{'{CMD_POST, KIND_ROOT, OP_REMOVE, 16'h0009, 16'h0001}, 1'b1, post_st(0, 1, 0, 3)},
      // item remove takes its own update and a link naming it as second id
      '{'{CMD_POST, KIND_FRAME_TREE, OP_ADD, 16'h000A, 16'h0005}, 1'b0, NO_RES},
      '{'{CMD_POST, KIND_ITEM, OP_REMOVE, 16'h0005, 16'h0000}, 1'b0, NO_RES},
      '{'{CMD_POST, KIND_ITEM, OP_REMOVE, 16'h1234, 16'h0000}, 1'b0, NO_RES},
      // a queued remove is not taken by an item remove
      '{'{CMD_POST, KIND_ITEM, OP_REMOVE, 16'h0000, 16'h0000}, 1'b0, NO_RES},
      // unused kind and unused op are stored as they are
      '{'{CMD_POST, KIND_UNUSED_HI, OP_REMOVE, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RES},
      '{'{CMD_POST, KIND_ROOT, OP_UNUSED, 16'hFFFF, 16'h0000}, 1'b0, NO_RES},
      '{'{CMD_POST, KIND_ITEM, OP_REMOVE, 16'hFFFF, 16'h0000}, 1'b0, NO_RES},
      '{'{CMD_POST, KIND_ROOT, OP_REMOVE, 16'hFFFF, 16'h0000}, 1'b0, NO_RES},
      '{'{CMD_POST, KIND_UNUSED_LO, OP_UPDATE, 16'h0001, 16'h0001}, 1'b0, NO_RES},
      '{'{CMD_DRAIN, KIND_ROOT, OP_UPDATE, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RES},
      '{'{CMD_DRAIN, KIND_ITEM, OP_ADD, 16'h0000, 16'h0000}, 1'b1,
        '{RES_EMPTY, 3'd0, 2'd0, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b1}}
    };

    // reset
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].res);
    wait_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      // receiver holds off while adds fill the queue past its depth
      if (ph == 0) begin
        hold_req = 1'b1;
        for (int k = 0; k < FILL_ITEMS; k++) begin
          c = '{CMD_POST, KIND_ITEM, OP_ADD, ID_W'(16'h0100 + k), ID_W'(k)};
          send_cmd(c, 1'b0, NO_RES);
        end
        wait_results();
        send_cmd('{CMD_DRAIN, KIND_ITEM, OP_ADD, 16'h0000, 16'h0000}, 1'b0, NO_RES);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) send_cmd(rand_cmd(), 1'b0, NO_RES);
      wait_results();
    end

    // let any stray result show up before the verdict
    wait_results();
    repeat (QUEUE_DEPTH + 4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("coalescing_event_queue_unit regression: pass");
    end else begin
      $display("coalescing_event_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
